@@ sv/sdep_pkg.sv @@
// Package for the data event parser: command and result codes, line phases,
// queue entry layout and the per-byte line decoding function.
// Depends on nothing; every module of the block uses it by scoped names.
package sdep_pkg;

  localparam int unsigned LenW   = 24;
  localparam int unsigned QDepth = 4;

  localparam logic [LenW-1:0] MaxLenReset = 24'h100000;

  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharColon = 8'h3A;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EVENT    = 2'd1,
    KIND_DISCARD  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  // Phases 0 to 3 count the letters of the field name matched so far.
  typedef enum logic [2:0] {
    PH_MATCH0 = 3'd0,
    PH_MATCH1 = 3'd1,
    PH_MATCH2 = 3'd2,
    PH_MATCH3 = 3'd3,
    PH_COLON  = 3'd4,
    PH_FIRST  = 3'd5,
    PH_VALUE  = 3'd6,
    PH_IGNORE = 3'd7
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } result_t;

  // Results caused by one accepted item, oldest in res0.
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } entry_t;

  typedef struct packed {
    phase_e     phase;
    logic       hp;
    logic       emit;
    logic [7:0] data;
  } line_t;

  function automatic logic [7:0] field_char(logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h64;
      2'd1:    c = 8'h61;
      2'd2:    c = 8'h74;
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  // One ordinary byte of a line, neither line feed nor a held carriage return.
  function automatic line_t line_byte(phase_e phase, logic hp, logic [7:0] c);
    line_t r;
    r.phase = phase;
    r.hp    = hp;
    r.emit  = 1'b0;
    r.data  = c;
    unique case (phase)
      PH_MATCH0, PH_MATCH1, PH_MATCH2, PH_MATCH3: begin
        r.phase = (c == field_char(phase[1:0])) ? phase_e'(phase + 3'd1) : PH_IGNORE;
      end
      PH_COLON: begin
        if (c == CharColon) begin
          r.emit  = hp;
          r.data  = CharLf;
          r.phase = PH_FIRST;
        end else begin
          r.phase = PH_IGNORE;
        end
      end
      PH_FIRST: begin
        r.emit  = (c != CharSpace);
        r.hp    = hp | (c != CharSpace);
        r.phase = PH_VALUE;
      end
      PH_VALUE: begin
        r.emit = 1'b1;
        r.hp   = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic entry_t append(entry_t e, kind_e kind, logic [7:0] data);
    entry_t r;
    r = e;
    if (e.num == 2'd0) begin
      r.res0.kind = kind;
      r.res0.data = data;
    end else begin
      r.res1.kind = kind;
      r.res1.data = data;
    end
    r.num = e.num + 2'd1;
    return r;
  endfunction

endpackage

@@ sv/sdep_front.sv @@
// Front part of the data event parser: accepts commands and stream bytes,
// keeps the line state and forms the results of each item as one queue entry.
// Depends on sdep_pkg.
module sdep_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [sdep_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              command_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output sdep_pkg::entry_t        q_entry_o
);

  logic [sdep_pkg::LenW-1:0] max_len_q;
  sdep_pkg::phase_e          phase_q, phase_d;
  logic                      pcr_q, pcr_d;
  logic                      hp_q, hp_d;
  logic [sdep_pkg::LenW-1:0] cnt_q, cnt_d;
  logic                      in_xfer;
  sdep_pkg::entry_t          ent;
  sdep_pkg::line_t           lb_cr, lb_b;

  assign in_stall_o = q_full_i;
  assign in_xfer    = in_valid_i & ~q_full_i;

  always_comb begin
    phase_d = phase_q;
    pcr_d   = pcr_q;
    hp_d    = hp_q;
    cnt_d   = cnt_q;
    ent     = '0;
    lb_cr   = '0;
    lb_b    = '0;
    unique case (command_i)
      sdep_pkg::CMD_BYTE: begin
        if (data_byte_i == sdep_pkg::CharLf) begin
          // The line is empty when it holds nothing but a held carriage return.
          if (cnt_q == {{(sdep_pkg::LenW-1){1'b0}}, pcr_q}) begin
            if (hp_q) begin
              ent  = sdep_pkg::append(ent, sdep_pkg::KIND_EVENT, 8'h00);
              hp_d = 1'b0;
            end
          end else if (phase_q == sdep_pkg::PH_COLON && hp_q) begin
            ent = sdep_pkg::append(ent, sdep_pkg::KIND_PAYLOAD, sdep_pkg::CharLf);
          end
          phase_d = sdep_pkg::PH_MATCH0;
          pcr_d   = 1'b0;
          cnt_d   = '0;
        end else if (cnt_q >= max_len_q) begin
          ent = sdep_pkg::append(ent, sdep_pkg::KIND_OVERFLOW, 8'h00);
        end else begin
          // A held carriage return not followed by a line feed is line content.
          if (pcr_q) begin
            lb_cr = sdep_pkg::line_byte(phase_q, hp_q, sdep_pkg::CharCr);
          end else begin
            lb_cr.phase = phase_q;
            lb_cr.hp    = hp_q;
          end
          if (lb_cr.emit) begin
            ent = sdep_pkg::append(ent, sdep_pkg::KIND_PAYLOAD, lb_cr.data);
          end
          if (data_byte_i == sdep_pkg::CharCr) begin
            lb_b.phase = lb_cr.phase;
            lb_b.hp    = lb_cr.hp;
            pcr_d      = 1'b1;
          end else begin
            lb_b  = sdep_pkg::line_byte(lb_cr.phase, lb_cr.hp, data_byte_i);
            pcr_d = 1'b0;
          end
          if (lb_b.emit) begin
            ent = sdep_pkg::append(ent, sdep_pkg::KIND_PAYLOAD, lb_b.data);
          end
          phase_d = lb_b.phase;
          hp_d    = lb_b.hp;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      sdep_pkg::CMD_FLUSH: begin
        if (phase_q == sdep_pkg::PH_COLON && hp_q) begin
          ent = sdep_pkg::append(ent, sdep_pkg::KIND_PAYLOAD, sdep_pkg::CharLf);
        end
        if (hp_q) begin
          ent = sdep_pkg::append(ent, sdep_pkg::KIND_EVENT, 8'h00);
        end
        hp_d    = 1'b0;
        phase_d = sdep_pkg::PH_MATCH0;
        pcr_d   = 1'b0;
        cnt_d   = '0;
      end
      sdep_pkg::CMD_CLEAR: begin
        if (hp_q) begin
          ent = sdep_pkg::append(ent, sdep_pkg::KIND_DISCARD, 8'h00);
        end
        hp_d    = 1'b0;
        phase_d = sdep_pkg::PH_MATCH0;
        pcr_d   = 1'b0;
        cnt_d   = '0;
      end
      default: begin
      end
    endcase
  end

  assign q_push_o  = in_xfer & (ent.num != 2'd0);
  assign q_entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= sdep_pkg::MaxLenReset;
      phase_q   <= sdep_pkg::PH_MATCH0;
      pcr_q     <= 1'b0;
      hp_q      <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        phase_q <= phase_d;
        pcr_q   <= pcr_d;
        hp_q    <= hp_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcr_q |-> (cnt_q != '0))
    else $error("held carriage return without a counted byte");

endmodule

@@ sv/sdep_fifo.sv @@
// Short queue between the front and back parts of the data event parser.
// Holds one entry per item that caused results. Depends on sdep_pkg.
module sdep_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sdep_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sdep_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (sdep_pkg::QDepth > 1) ? $clog2(sdep_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(sdep_pkg::QDepth + 1);

  sdep_pkg::entry_t mem_q [sdep_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(sdep_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(sdep_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue read while empty");

endmodule

@@ sv/sdep_back.sv @@
// Back part of the data event parser: takes queue entries and hands their
// results out one transfer at a time from registers. Depends on sdep_pkg.
module sdep_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  sdep_pkg::entry_t q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o
);

  logic              valid_q;
  sdep_pkg::result_t cur_q;
  sdep_pkg::result_t nxt_q;
  logic              has_nxt_q;
  logic              out_xfer;

  assign out_xfer = valid_q & ~out_stall_i;
  // A new entry is loaded once the register is empty or its last result leaves.
  assign q_pop_o  = ~q_empty_i & (~valid_q | (out_xfer & ~has_nxt_q));

  assign out_valid_o = valid_q;
  assign kind_o      = cur_q.kind;
  assign out_byte_o  = cur_q.data;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i.res0;
      nxt_q <= q_head_i.res1;
    end else if (out_xfer && has_nxt_q) begin
      cur_q <= nxt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      has_nxt_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        valid_q   <= 1'b1;
        has_nxt_q <= (q_head_i.num == 2'd2);
      end else if (out_xfer) begin
        valid_q   <= has_nxt_q;
        has_nxt_q <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_nxt_q |-> valid_q)
    else $error("second result held without a first");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (q_head_i.num == 2'd1 || q_head_i.num == 2'd2))
    else $error("queue entry without results");

endmodule

@@ sv/sse_data_event_parser.sv @@
// Top level of the data event parser: front part, entry queue and back part.
// Depends on sdep_pkg, sdep_front, sdep_fifo and sdep_back.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   command_i, data_byte_i
//   out      output     out_valid_o / out_stall_i kind_o, out_byte_o
//   cfg      input      cfg_we_i                  cfg_wdata_i (max line length)
//
// One item is taken every cycle while the queue is not full; its first result
// passes through the queue and then the output register before it is offered,
// one transfer per cycle while out_stall_i is low. An item with two results needs two
// output transfers, which sets the sustained rate. The input stalls only when the
// four-entry queue is full. Reset clears the line state, the queue and the output
// register, and loads the maximum line length of 1048576.
module sse_data_event_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sdep_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                command_i,
  input  logic [7:0]                data_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                out_byte_o
);

  logic             q_push, q_pop, q_full, q_empty;
  sdep_pkg::entry_t q_wr_entry, q_head;

  sdep_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_wr_entry)
  );

  sdep_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_wr_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  sdep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for sse_data_event_parser: random and directed byte streams
// are checked against a line parser that runs beside the block in a scoreboard class.
// Depends on sdep_pkg and sse_data_event_parser.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0]  CmdUnused    = 2'd3;
  localparam logic [31:0] FieldText    = "data";
  localparam int          SettleCycles = 12;
  localparam int          HoldCycles   = 60;
  localparam int          CycleLimit   = 200000;
  localparam int          MaxReports   = 40;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] b;
  } stim_t;

  class parser_scoreboard;
    logic [sdep_pkg::LenW-1:0] max_len;
    sdep_pkg::phase_e          phase;
    bit                        cr_held;
    bit                        payload_seen;
    logic [sdep_pkg::LenW-1:0] line_len;
    sdep_pkg::result_t         awaited_results[$];
    int                        n_items;
    int                        n_errors;
    int                        cmd_count[4];
    int                        kind_count[4];

    function new();
      max_len      = sdep_pkg::MaxLenReset;
      payload_seen = 1'b0;
      start_line();
    endfunction

    function void start_line();
      phase    = sdep_pkg::PH_MATCH0;
      cr_held  = 1'b0;
      line_len = '0;
    endfunction

    function void await_result(sdep_pkg::kind_e k, logic [7:0] d);
      sdep_pkg::result_t r;
      r.kind = k;
      r.data = d;
      awaited_results.push_back(r);
      if (k == sdep_pkg::KIND_PAYLOAD) payload_seen = 1'b1;
    endfunction

    // An ordinary byte of the line: neither a line feed nor a held carriage return.
    function void take_line_byte(logic [7:0] c);
      case (phase)
        sdep_pkg::PH_MATCH0, sdep_pkg::PH_MATCH1, sdep_pkg::PH_MATCH2,
        sdep_pkg::PH_MATCH3: begin
          if (c == FieldText[8*(3-int'(phase)) +: 8])
            phase = sdep_pkg::phase_e'(phase + 3'd1);
          else phase = sdep_pkg::PH_IGNORE;
        end
        sdep_pkg::PH_COLON: begin
          if (c == sdep_pkg::CharColon) begin
            if (payload_seen) await_result(sdep_pkg::KIND_PAYLOAD, sdep_pkg::CharLf);
            phase = sdep_pkg::PH_FIRST;
          end else begin
            phase = sdep_pkg::PH_IGNORE;
          end
        end
        sdep_pkg::PH_FIRST: begin
          if (c != sdep_pkg::CharSpace) await_result(sdep_pkg::KIND_PAYLOAD, c);
          phase = sdep_pkg::PH_VALUE;
        end
        sdep_pkg::PH_VALUE: begin
          await_result(sdep_pkg::KIND_PAYLOAD, c);
        end
        default: begin
        end
      endcase
    endfunction

    function void parse_item(logic [1:0] cmd, logic [7:0] b);
      n_items++;
      cmd_count[cmd]++;
      case (cmd)
        sdep_pkg::CMD_BYTE: begin
          if (b == sdep_pkg::CharLf) begin
            // A held carriage return does not make the line non-empty.
            if (line_len == sdep_pkg::LenW'(cr_held)) begin
              if (payload_seen) await_result(sdep_pkg::KIND_EVENT, 8'h00);
              payload_seen = 1'b0;
            end else if (phase == sdep_pkg::PH_COLON && payload_seen) begin
              await_result(sdep_pkg::KIND_PAYLOAD, sdep_pkg::CharLf);
            end
            start_line();
          end else if (line_len >= max_len) begin
            await_result(sdep_pkg::KIND_OVERFLOW, 8'h00);
          end else begin
            if (cr_held) begin
              cr_held = 1'b0;
              take_line_byte(sdep_pkg::CharCr);
            end
            if (b == sdep_pkg::CharCr) cr_held = 1'b1;
            else take_line_byte(b);
            line_len = line_len + 1'b1;
          end
        end
        sdep_pkg::CMD_FLUSH: begin
          if (phase == sdep_pkg::PH_COLON && payload_seen)
            await_result(sdep_pkg::KIND_PAYLOAD, sdep_pkg::CharLf);
          if (payload_seen) await_result(sdep_pkg::KIND_EVENT, 8'h00);
          payload_seen = 1'b0;
          start_line();
        end
        sdep_pkg::CMD_CLEAR: begin
          if (payload_seen) await_result(sdep_pkg::KIND_DISCARD, 8'h00);
          payload_seen = 1'b0;
          start_line();
        end
        default: begin
        end
      endcase
    endfunction

    function void report(string what, int exp_val, int act_val);
      n_errors++;
      if (n_errors <= MaxReports)
        $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, what, exp_val,
                 act_val);
    endfunction

    function void compare_result(logic [1:0] kind, logic [7:0] b);
      sdep_pkg::result_t exp_res;
      if (awaited_results.size() == 0) begin
        report("unexpected transfer, kind", -1, kind);
        return;
      end
      exp_res = awaited_results.pop_front();
      kind_count[kind]++;
      if (kind !== exp_res.kind) report("kind", exp_res.kind, kind);
      if (b !== exp_res.data) report("out_byte", exp_res.data, b);
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [sdep_pkg::LenW-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                command_i = sdep_pkg::CMD_BYTE;
  logic [7:0]                data_byte_i = 8'h00;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [1:0]                kind_o;
  logic [7:0]                out_byte_o;

  parser_scoreboard sb = new();
  stim_t            stim_q[$];
  int               stall_pct = 0;
  int               hold_trigger = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               cycle_cnt = 0;

  sse_data_event_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off each time one is requested.
  always @(posedge clk_i) begin
    if (hold_seen != hold_trigger) begin
      hold_seen   <= hold_trigger;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.compare_result(kind_o, out_byte_o);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_cnt,
               sb.awaited_results.size());
      $display("sse_data_event_parser test failed");
      $finish;
    end
  end

  function automatic void push_item(logic [1:0] cmd, logic [7:0] b);
    stim_t it;
    it.cmd = cmd;
    it.b   = b;
    stim_q.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(sdep_pkg::CMD_BYTE, s[i]);
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) c = sdep_pkg::CharCr;
    else if (c == sdep_pkg::CharLf) c = sdep_pkg::CharSpace;
    return c;
  endfunction

  function automatic void push_value(int len);
    for (int i = 0; i < len; i++) push_item(sdep_pkg::CMD_BYTE, value_byte());
  endfunction

  function automatic void push_line_end();
    int r;
    r = $urandom_range(0, 9);
    if (r >= 9) push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharCr);
    if (r >= 6) push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharCr);
    push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharLf);
  endfunction

  // One line, mostly well formed, with near misses and raw noise now and then.
  function automatic void push_random_line();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        push_text("data:");
        if ($urandom_range(0, 1) == 1) push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharSpace);
        push_value($urandom_range(0, 6));
      end
      5: push_text("data");
      6: begin
        push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharColon);
        push_value($urandom_range(0, 5));
      end
      7: begin
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) push_item(sdep_pkg::CMD_BYTE, FieldText[8*(3-i) +: 8]);
        push_item(sdep_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
        push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharColon);
        push_value($urandom_range(0, 4));
      end
      8: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push_item(sdep_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      end
      default: begin
        push_text("data: ");
        push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharCr);
        push_value($urandom_range(1, 4));
        push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharCr);
      end
    endcase
    if ($urandom_range(0, 7) != 0) push_line_end();
  endfunction

  function automatic void push_random_event();
    int lines;
    lines = $urandom_range(1, 3);
    for (int i = 0; i < lines; i++) push_random_line();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if ($urandom_range(0, 2) == 0) push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharCr);
        push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharLf);
      end
      6: push_item(sdep_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
      7: push_item(sdep_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
      8: push_item(CmdUnused, 8'($urandom_range(0, 255)));
      default: begin
      end
    endcase
  endfunction

  task automatic drive_items(int idle_pct);
    stim_t it;
    while (stim_q.size() > 0) begin
      it = stim_q.pop_front();
      while ($urandom_range(0, 99) < idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      command_i   <= it.cmd;
      data_byte_i <= it.b;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      sb.parse_item(it.cmd, it.b);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic run_random(int n_items, int idle_pct, int stall);
    stall_pct <= stall;
    while (stim_q.size() < n_items) push_random_event();
    drive_items(idle_pct);
  endtask

  // Lines with no result may still be inside the block once the last result is out.
  task automatic wait_quiet();
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_max_len(logic [sdep_pkg::LenW-1:0] len);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.max_len = len;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Space skipped after the colon, CR LF ending, bare data line as a separator,
    // the unused command, a blank line, a held carriage return, a clear and a flush.
    push_text("data: ");
    push_item(sdep_pkg::CMD_BYTE, 8'hFF);
    push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharCr);
    push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharLf);
    push_text("data");
    push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharLf);
    push_item(CmdUnused, 8'hFF);
    push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharLf);
    push_text("data:");
    push_item(sdep_pkg::CMD_BYTE, 8'h00);
    push_item(sdep_pkg::CMD_BYTE, sdep_pkg::CharCr);
    push_item(sdep_pkg::CMD_CLEAR, 8'h00);
    push_item(sdep_pkg::CMD_FLUSH, 8'hFF);
    drive_items(0);

    set_max_len('1);
    run_random(120, 0, 0);
    set_max_len(24'd6);
    run_random(90, 60, 0);
    set_max_len(24'd1);
    run_random(40, 0, 0);
    set_max_len('0);
    run_random(30, 29, 29);
    set_max_len(24'd12);
    hold_trigger <= hold_trigger + 1;
    run_random(100, 0, 60);
    set_max_len(24'd40);
    run_random(100, 29, 29);

    wait_quiet();
    if (sb.awaited_results.size() != 0) sb.report("leftover results", 0, 0);
    $display("Run covered %0d items (bytes %0d, flush %0d, clear %0d, unused %0d),",
             sb.n_items, sb.cmd_count[sdep_pkg::CMD_BYTE], sb.cmd_count[sdep_pkg::CMD_FLUSH],
             sb.cmd_count[sdep_pkg::CMD_CLEAR], sb.cmd_count[CmdUnused]);
    $display("  giving payload %0d, event %0d, discard %0d, overflow %0d transfers.",
             sb.kind_count[sdep_pkg::KIND_PAYLOAD], sb.kind_count[sdep_pkg::KIND_EVENT],
             sb.kind_count[sdep_pkg::KIND_DISCARD], sb.kind_count[sdep_pkg::KIND_OVERFLOW]);
    if (sb.n_errors == 0) begin
      $display("sse_data_event_parser test passed");
    end else begin
      $display("%0d mismatches found.", sb.n_errors);
      $display("sse_data_event_parser test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/sdep_pkg.sv
sv/sdep_front.sv
sv/sdep_fifo.sv
sv/sdep_back.sv
sv/sse_data_event_parser.sv
dv/tb.sv
